// ===== src/isd_pkg.sv =====
package isd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ACCEL_ENERGY_W = 2 * SAMPLE_BITS + 1;
    localparam int GYRO_ENERGY_W = 2 * SAMPLE_BITS;
    localparam int SUM_W = 41;
    localparam int COUNT_W = 9;
    localparam int GRAVITY_W = 15;
    localparam int LIMIT_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int DEFAULT_MAX_WINDOW = 256;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 15'd20081;
    localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RESET = 16'd102;
    localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RESET = 16'd41;
    localparam int WINDOW_RESET = 200;

    typedef enum logic [1:0] {
        CFG_GRAVITY_LEVEL,
        CFG_ACCEL_RMS_LIMIT,
        CFG_GYRO_RMS_LIMIT,
        CFG_WINDOW_LENGTH
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic signed [SAMPLE_BITS-1:0] rate_x;
        logic signed [SAMPLE_BITS-1:0] rate_y;
        logic signed [SAMPLE_BITS-1:0] rate_z;
    } sample_t;

    typedef struct packed {
        logic                      sample_taken;
        logic [COUNT_W-1:0]        sample_count;
        logic [SUM_W-1:0]          accel_energy_sum;
        logic [SUM_W-1:0]          gyro_energy_sum;
        logic                      stationary;
    } result_t;

    typedef struct packed {
        logic                      taken;
        logic [ACCEL_ENERGY_W-1:0] accel_energy;
        logic [GYRO_ENERGY_W-1:0]  gyro_energy;
    } energy_t;

    typedef struct packed {
        logic                      clear;
        logic [COUNT_W-1:0]        window_len;
        logic [SUM_W-1:0]          accel_thr;
        logic [SUM_W-1:0]          gyro_thr;
    } window_ctrl_t;

endpackage

// ===== src/imu_stationary_detector_core.sv =====
// IMU stationary detector.
// Samples enter through a queue-style port: a request is taken at a rising edge
// with push high and full low. Results leave the same way: the oldest result is
// shown while empty is low and is taken at an edge with pop high.
// Every request yields exactly one result, in order. An all-zero sample is
// reported with sample_taken low and leaves the window unchanged.
// A request passes the front, middle queue, back and result queue before empty
// falls. One request per cycle is sustained while full is low; the running sum
// update sets the rate: one read and one write of the energy store per cycle.
// The front squares and sums the axes in two stages and feeds a short queue;
// the back updates the window and feeds the result queue.
// When pop is held low the result queue fills, the back stops pulling, the
// middle queue fills and full rises; no request is dropped.
// Reset empties both queues and the window and loads the default registers.
// A write of the window length empties the window; the store itself needs no
// clearing, since an entry is read only after it has been written.
// The user writes registers only while no request is in flight; not enforced.
module imu_stationary_detector_core #(
    parameter int MAX_WINDOW = isd_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  isd_pkg::sample_t               sample,
    output logic                           empty,
    input  logic                           pop,
    output isd_pkg::result_t               result,
    input  logic                           cfg_write,
    input  isd_pkg::cfg_index_t            cfg_index,
    input  logic [isd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import isd_pkg::*;

    localparam int WIN_CAP_INT = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
    localparam logic [COUNT_W-1:0] WIN_CAP = COUNT_W'(WIN_CAP_INT);
    localparam logic [COUNT_W-1:0] WIN_RESET =
        COUNT_W'((WINDOW_RESET < WIN_CAP_INT) ? WINDOW_RESET : WIN_CAP_INT);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [GRAVITY_W-1:0]   gravity_reg;
    logic [LIMIT_W-1:0]     accel_limit_reg;
    logic [LIMIT_W-1:0]     gyro_limit_reg;
    logic [COUNT_W-1:0]     window_reg;
    logic [COUNT_W-1:0]     window_next;
    logic [2*LIMIT_W-1:0]   accel_sq_reg;
    logic [2*LIMIT_W-1:0]   gyro_sq_reg;
    logic [SUM_W-1:0]       accel_thr_reg;
    logic [SUM_W-1:0]       accel_thr_next;
    logic [SUM_W-1:0]       gyro_thr_reg;
    logic [SUM_W-1:0]       gyro_thr_next;

    window_ctrl_t           ctrl;
    logic                   accept;
    logic [1:0]             front_inflight;
    logic                   front_valid;
    energy_t                front_item;
    energy_t                mid_item;
    logic                   mid_empty;
    logic [QCW-1:0]         mid_count;
    logic                   mid_pop;
    logic [1:0]             win_inflight;
    logic                   win_valid;
    result_t                win_item;
    logic [QCW-1:0]         res_count;
    logic [QCW:0]           front_load;
    logic [QCW:0]           res_load;

    always_comb
    begin
        window_next = cfg_data[COUNT_W-1:0];
        if (window_next == '0)
        begin
            window_next = COUNT_W'(1);
        end
        else if (window_next > WIN_CAP)
        begin
            window_next = WIN_CAP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
            accel_limit_reg <= ACCEL_LIMIT_RESET;
            gyro_limit_reg <= GYRO_LIMIT_RESET;
            window_reg <= WIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GRAVITY_LEVEL:   gravity_reg <= cfg_data[GRAVITY_W-1:0];
                CFG_ACCEL_RMS_LIMIT: accel_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_GYRO_RMS_LIMIT:  gyro_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_WINDOW_LENGTH:   window_reg <= window_next;
                default:             gravity_reg <= gravity_reg;
            endcase
        end
    end

    assign accel_thr_next = SUM_W'(accel_sq_reg) * SUM_W'(window_reg);
    assign gyro_thr_next = SUM_W'(gyro_sq_reg) * SUM_W'(window_reg);

    always_ff @(posedge clk)
    begin
        accel_sq_reg <= (2*LIMIT_W)'(accel_limit_reg) * (2*LIMIT_W)'(accel_limit_reg);
        gyro_sq_reg <= (2*LIMIT_W)'(gyro_limit_reg) * (2*LIMIT_W)'(gyro_limit_reg);
        accel_thr_reg <= accel_thr_next;
        gyro_thr_reg <= gyro_thr_next;
    end

    always_comb
    begin
        ctrl.clear = cfg_write && (cfg_index == CFG_WINDOW_LENGTH);
        ctrl.window_len = window_reg;
        ctrl.accel_thr = accel_thr_reg;
        ctrl.gyro_thr = gyro_thr_reg;
    end

    assign front_load = (QCW+1)'(mid_count) + (QCW+1)'(front_inflight);
    assign full = (front_load >= (QCW+1)'(QUEUE_DEPTH));
    assign accept = push && !full;

    assign res_load = (QCW+1)'(res_count) + (QCW+1)'(win_inflight);
    assign mid_pop = !mid_empty && (res_load < (QCW+1)'(QUEUE_DEPTH));

    isd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .sample    (sample),
        .gravity   (gravity_reg),
        .out_valid (front_valid),
        .out_item  (front_item),
        .inflight  (front_inflight)
    );

    isd_queue #(
        .item_t (energy_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .pop       (mid_pop),
        .pop_item  (mid_item),
        .empty     (mid_empty),
        .count     (mid_count)
    );

    isd_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (mid_pop),
        .in_item   (mid_item),
        .out_valid (win_valid),
        .out_item  (win_item),
        .inflight  (win_inflight)
    );

    isd_queue #(
        .item_t (result_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (win_valid),
        .push_item (win_item),
        .pop       (pop),
        .pop_item  (result),
        .empty     (empty),
        .count     (res_count)
    );

endmodule

// ===== src/isd_queue.sv =====
module isd_queue #(
    parameter type item_t = logic,
    parameter int DEPTH = isd_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      push_item,
    input  logic                       pop,
    output item_t                      pop_item,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import isd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t            store [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             pop_ok;

    always_comb
    begin
        pop_ok = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && pop_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    assign pop_item = store[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// ===== src/isd_front.sv =====
module isd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  isd_pkg::sample_t                  sample,
    input  logic [isd_pkg::GRAVITY_W-1:0]     gravity,
    output logic                              out_valid,
    output isd_pkg::energy_t                  out_item,
    output logic [1:0]                        inflight
);
    import isd_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic signed [2*SB-1:0]   p_ax;
    logic signed [2*SB-1:0]   p_ay;
    logic signed [SB:0]       az_diff;
    logic signed [2*SB+1:0]   p_az;
    logic signed [2*SB-1:0]   p_rx;
    logic signed [2*SB-1:0]   p_ry;
    logic signed [2*SB-1:0]   p_rz;

    logic                     v1_reg;
    logic                     taken1_reg;
    logic [2*SB-2:0]          sq_ax_reg;
    logic [2*SB-2:0]          sq_ay_reg;
    logic [2*SB-1:0]          sq_az_reg;
    logic [2*SB-2:0]          sq_rx_reg;
    logic [2*SB-2:0]          sq_ry_reg;
    logic [2*SB-2:0]          sq_rz_reg;

    logic                     v2_reg;
    energy_t                  e2_reg;
    energy_t                  e2_next;

    always_comb
    begin
        p_ax = (2*SB)'(sample.accel_x) * (2*SB)'(sample.accel_x);
        p_ay = (2*SB)'(sample.accel_y) * (2*SB)'(sample.accel_y);
        az_diff = $signed({sample.accel_z[SB-1], sample.accel_z})
                - $signed({{(SB + 1 - GRAVITY_W){1'b0}}, gravity});
        p_az = (2*SB+2)'(az_diff) * (2*SB+2)'(az_diff);
        p_rx = (2*SB)'(sample.rate_x) * (2*SB)'(sample.rate_x);
        p_ry = (2*SB)'(sample.rate_y) * (2*SB)'(sample.rate_y);
        p_rz = (2*SB)'(sample.rate_z) * (2*SB)'(sample.rate_z);
    end

    always_comb
    begin
        e2_next.taken = taken1_reg;
        e2_next.accel_energy = ACCEL_ENERGY_W'(sq_ax_reg) + ACCEL_ENERGY_W'(sq_ay_reg)
                             + ACCEL_ENERGY_W'(sq_az_reg);
        e2_next.gyro_energy = GYRO_ENERGY_W'(sq_rx_reg) + GYRO_ENERGY_W'(sq_ry_reg)
                            + GYRO_ENERGY_W'(sq_rz_reg);
    end

    always_ff @(posedge clk)
    begin
        taken1_reg <= |sample;
        sq_ax_reg <= p_ax[2*SB-2:0];
        sq_ay_reg <= p_ay[2*SB-2:0];
        sq_az_reg <= p_az[2*SB-1:0];
        sq_rx_reg <= p_rx[2*SB-2:0];
        sq_ry_reg <= p_ry[2*SB-2:0];
        sq_rz_reg <= p_rz[2*SB-2:0];
        e2_reg <= e2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_item = e2_reg;
    assign inflight = {1'b0, v1_reg} + {1'b0, v2_reg};

endmodule

// ===== src/isd_window.sv =====
module isd_window #(
    parameter int MAX_WINDOW = isd_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  isd_pkg::window_ctrl_t   ctrl,
    input  logic                    in_valid,
    input  isd_pkg::energy_t        in_item,
    output logic                    out_valid,
    output isd_pkg::result_t        out_item,
    output logic [1:0]              inflight
);
    import isd_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

    logic [ACCEL_ENERGY_W-1:0] accel_store [MAX_WINDOW];
    logic [GYRO_ENERGY_W-1:0]  gyro_store [MAX_WINDOW];

    logic [AW-1:0]             pos_reg;
    logic [AW-1:0]             pos_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [PW-1:0]             pos_inc;
    logic                      take;
    logic                      full_now;

    logic                      b_v_reg;
    logic                      b_take_reg;
    logic                      b_evict_reg;
    logic                      b_full_reg;
    logic [COUNT_W-1:0]        b_count_reg;
    logic [ACCEL_ENERGY_W-1:0] b_ae_reg;
    logic [GYRO_ENERGY_W-1:0]  b_ge_reg;
    logic [ACCEL_ENERGY_W-1:0] accel_rd_reg;
    logic [GYRO_ENERGY_W-1:0]  gyro_rd_reg;

    logic                      s_v_reg;
    logic                      s_take_reg;
    logic                      s_full_reg;
    logic [COUNT_W-1:0]        s_count_reg;
    logic [SUM_W-1:0]          accel_sum_reg;
    logic [SUM_W-1:0]          accel_sum_next;
    logic [SUM_W-1:0]          gyro_sum_reg;
    logic [SUM_W-1:0]          gyro_sum_next;

    always_comb
    begin
        take = in_valid && in_item.taken;
        full_now = (count_reg >= ctrl.window_len);
        count_next = (take && !full_now) ? count_reg + COUNT_W'(1) : count_reg;
        pos_inc = PW'(pos_reg) + PW'(1);
        pos_next = pos_reg;
        if (take)
        begin
            pos_next = (pos_inc >= PW'(ctrl.window_len)) ? '0 : pos_inc[AW-1:0];
        end
    end

    always_comb
    begin
        accel_sum_next = accel_sum_reg;
        gyro_sum_next = gyro_sum_reg;
        if (b_v_reg && b_take_reg)
        begin
            accel_sum_next = accel_sum_reg + SUM_W'(b_ae_reg)
                           - (b_evict_reg ? SUM_W'(accel_rd_reg) : '0);
            gyro_sum_next = gyro_sum_reg + SUM_W'(b_ge_reg)
                          - (b_evict_reg ? SUM_W'(gyro_rd_reg) : '0);
        end
    end

    // The read sees the entry before this cycle's write, the evicted one when full.
    always_ff @(posedge clk)
    begin
        accel_rd_reg <= accel_store[pos_reg];
        gyro_rd_reg <= gyro_store[pos_reg];
        if (take)
        begin
            accel_store[pos_reg] <= in_item.accel_energy;
            gyro_store[pos_reg] <= in_item.gyro_energy;
        end
    end

    always_ff @(posedge clk)
    begin
        b_take_reg <= take;
        b_evict_reg <= take && full_now;
        b_count_reg <= count_next;
        b_full_reg <= (count_next >= ctrl.window_len);
        b_ae_reg <= in_item.accel_energy;
        b_ge_reg <= in_item.gyro_energy;
        s_take_reg <= b_take_reg;
        s_count_reg <= b_count_reg;
        s_full_reg <= b_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            count_reg <= '0;
            accel_sum_reg <= '0;
            gyro_sum_reg <= '0;
            b_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            pos_reg <= '0;
            count_reg <= '0;
            accel_sum_reg <= '0;
            gyro_sum_reg <= '0;
            b_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            count_reg <= count_next;
            accel_sum_reg <= accel_sum_next;
            gyro_sum_reg <= gyro_sum_next;
            b_v_reg <= in_valid;
            s_v_reg <= b_v_reg;
        end
    end

    always_comb
    begin
        out_item.sample_taken = s_take_reg;
        out_item.sample_count = s_count_reg;
        out_item.accel_energy_sum = accel_sum_reg;
        out_item.gyro_energy_sum = gyro_sum_reg;
        out_item.stationary = s_full_reg && (accel_sum_reg < ctrl.accel_thr)
                            && (gyro_sum_reg < ctrl.gyro_thr);
    end

    assign out_valid = s_v_reg;
    assign inflight = {1'b0, b_v_reg} + {1'b0, s_v_reg};

endmodule

// ===== src/isd_checker.sv =====
module isd_checker #(
    parameter int MAX_WINDOW = isd_pkg::DEFAULT_MAX_WINDOW
) (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input isd_pkg::result_t  result
);
    import isd_pkg::*;

    localparam int CAP = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;

    logic [4:0] outstanding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 5'(push && !full) - 5'(pop && !empty);
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not idle in reset");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> outstanding_reg != 5'd0)
        else $error("result shown with no request outstanding");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.sample_count <= COUNT_W'(CAP))
        else $error("sample count above window capacity");

    a_stationary_needs_samples: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.stationary |-> result.sample_count != '0)
        else $error("stationary flagged on an empty window");

endmodule

bind imu_stationary_detector_core isd_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_isd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
